@@ hw/rtl/iq_phase_rotator_defines.svh @@
// Assertion macros used by the port-level checker of the phase rotator.
`ifndef IQ_PHASE_ROTATOR_DEFINES_SVH
`define IQ_PHASE_ROTATOR_DEFINES_SVH

// Clocked assertion that is disabled while reset is asserted.
`define IRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication that is disabled while reset is asserted.
`define IRP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/irot_pkg.sv @@
// Shared constants, register codes and a helper function for the phase rotator.
`default_nettype none

package irot_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int TRIG_BITS_DEF  = 16;
    localparam int PHASE_W        = 32;
    localparam int SAMPLE_W       = 8;
    localparam int SAMPLE_OFFSET  = 128;
    localparam int DATA_W         = 2 * SAMPLE_W;
    localparam int CFG_ADDR_W     = 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int MAX_IN_FLIGHT  = QUEUE_DEPTH + 3;

    localparam real TWO_PI  = 6.28318530717959;
    localparam real HALF_PI = TWO_PI / 4.0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PHASE_STEP = 1'b0,
        REG_DRIFT_MODE = 1'b1
    } cfg_reg_t;

    // Rounded amplitude times the cosine of a first-quadrant angle.
    function automatic int scaled_cos(input real ang, input int amp);
        real v;
        v = amp * $cos(ang);
        return $rtoi(v + 0.5);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/irot_front.sv @@
// Front end: configuration registers, angle accumulator and item classification.
`default_nettype none

module irot_front #(
    parameter int ANGLE_BITS = irot_pkg::ANGLE_BITS_DEF,
    parameter int ENTRY_W    = irot_pkg::DATA_W + ANGLE_BITS + 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [irot_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [irot_pkg::PHASE_W-1:0]    cfg_wdata,
    input  wire logic                            in_valid,
    input  wire logic [irot_pkg::DATA_W-1:0]     in_data,
    input  wire logic                            queue_ready,
    output logic                                 push,
    output logic [ENTRY_W-1:0]                   entry
);

    logic [irot_pkg::PHASE_W-1:0] phase_step_reg;
    logic                         drift_mode_reg;
    logic [irot_pkg::PHASE_W-1:0] acc_reg;
    logic [irot_pkg::PHASE_W-1:0] acc_next;
    logic                         first_reg;
    logic [irot_pkg::PHASE_W-1:0] angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            drift_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (irot_pkg::cfg_reg_t'(cfg_addr))
                irot_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                irot_pkg::REG_DRIFT_MODE: drift_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign push     = in_valid && queue_ready;
    assign angle    = drift_mode_reg ? acc_reg : phase_step_reg;
    assign acc_next = acc_reg + phase_step_reg;

    // The accumulator advances with every sample in either mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (push)
        begin
            acc_reg   <= acc_next;
            first_reg <= 1'b0;
        end
    end

    assign entry = {first_reg, angle[irot_pkg::PHASE_W-1 -: ANGLE_BITS], in_data};

endmodule

`default_nettype wire

@@ hw/rtl/irot_queue.sv @@
// Short first-in first-out queue between the front end and the datapath.
`default_nettype none

module irot_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = irot_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/irot_back.sv @@
// Datapath: quarter-wave table lookup, complex multiply and saturation to offset binary, or raw pass-through.
`default_nettype none

module irot_back #(
    parameter int ANGLE_BITS = irot_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_BITS  = irot_pkg::TRIG_BITS_DEF,
    parameter int ENTRY_W    = irot_pkg::DATA_W + ANGLE_BITS + 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        entry_valid,
    input  wire logic [ENTRY_W-1:0]          entry,
    output logic                             entry_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [irot_pkg::DATA_W-1:0]      out_data
);

    localparam int SW      = irot_pkg::SAMPLE_W;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int RA      = ANGLE_BITS - 1;
    localparam int MW      = TRIG_BITS - 1;
    localparam int AMP     = (1 << (TRIG_BITS - 1)) - 1;
    localparam int PW      = TRIG_BITS + SW;
    localparam int VW      = TRIG_BITS + SW + 2;

    logic [MW-1:0] qtab [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_qtab
        localparam real ANG = irot_pkg::HALF_PI * g / QUARTER;
        assign qtab[g] = MW'(irot_pkg::scaled_cos(ANG, AMP));
    end

    logic                   adv;
    logic [SW-1:0]          e_i;
    logic [SW-1:0]          e_q;
    logic [ANGLE_BITS-1:0]  e_k;
    logic                   e_bypass;
    logic [RA-1:0]          addr_a;
    logic [RA-1:0]          addr_b;

    logic                   s1_valid_reg;
    logic [MW-1:0]          s1_a_reg;
    logic [MW-1:0]          s1_b_reg;
    logic [1:0]             s1_quad_reg;
    logic signed [SW-1:0]   s1_i_reg;
    logic signed [SW-1:0]   s1_q_reg;
    logic                   s1_bypass_reg;
    logic [irot_pkg::DATA_W-1:0] s1_raw_reg;

    logic signed [TRIG_BITS-1:0] pos_a;
    logic signed [TRIG_BITS-1:0] pos_b;
    logic signed [TRIG_BITS-1:0] cos_v;
    logic signed [TRIG_BITS-1:0] sin_v;

    logic                   s2_valid_reg;
    logic signed [PW-1:0]   s2_ic_reg;
    logic signed [PW-1:0]   s2_qs_reg;
    logic signed [PW-1:0]   s2_is_reg;
    logic signed [PW-1:0]   s2_qc_reg;
    logic                   s2_bypass_reg;
    logic [irot_pkg::DATA_W-1:0] s2_raw_reg;

    logic signed [VW-1:0]   t_i;
    logic signed [VW-1:0]   t_q;
    logic                   out_valid_reg;
    logic [irot_pkg::DATA_W-1:0] out_data_reg;

    function automatic logic [SW-1:0] finish(input logic signed [VW-1:0] t);
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] sh;
        v  = t + (VW'(irot_pkg::SAMPLE_OFFSET) <<< (TRIG_BITS - 1));
        sh = v >>> (TRIG_BITS - 1);
        if (v < 0)
        begin
            return '0;
        end
        else if (sh > VW'((1 << SW) - 1))
        begin
            return '1;
        end
        else
        begin
            return sh[SW-1:0];
        end
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign entry_pop = adv;

    assign e_i      = entry[SW-1:0];
    assign e_q      = entry[2*SW-1:SW];
    assign e_k      = entry[2*SW +: ANGLE_BITS];
    assign e_bypass = entry[ENTRY_W-1];
    assign addr_a   = {1'b0, e_k[ANGLE_BITS-3:0]};
    assign addr_b   = RA'(QUARTER) - addr_a;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg      <= qtab[addr_a];
            s1_b_reg      <= qtab[addr_b];
            s1_quad_reg   <= e_k[ANGLE_BITS-1 -: 2];
            s1_i_reg      <= {~e_i[SW-1], e_i[SW-2:0]};
            s1_q_reg      <= {~e_q[SW-1], e_q[SW-2:0]};
            s1_bypass_reg <= e_bypass;
            s1_raw_reg    <= entry[irot_pkg::DATA_W-1:0];
        end
    end

    assign pos_a = signed'({1'b0, s1_a_reg});
    assign pos_b = signed'({1'b0, s1_b_reg});

    always_comb
    begin
        unique case (s1_quad_reg)
            2'd0:
            begin
                cos_v = pos_a;
                sin_v = pos_b;
            end
            2'd1:
            begin
                cos_v = -pos_b;
                sin_v = pos_a;
            end
            2'd2:
            begin
                cos_v = -pos_a;
                sin_v = -pos_b;
            end
            default:
            begin
                cos_v = pos_b;
                sin_v = -pos_a;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ic_reg     <= PW'(s1_i_reg) * PW'(cos_v);
            s2_qs_reg     <= PW'(s1_q_reg) * PW'(sin_v);
            s2_is_reg     <= PW'(s1_i_reg) * PW'(sin_v);
            s2_qc_reg     <= PW'(s1_q_reg) * PW'(cos_v);
            s2_bypass_reg <= s1_bypass_reg;
            s2_raw_reg    <= s1_raw_reg;
        end
    end

    assign t_i = VW'(s2_ic_reg) - VW'(s2_qs_reg);
    assign t_q = VW'(s2_is_reg) + VW'(s2_qc_reg);

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            out_data_reg <= s2_bypass_reg ? s2_raw_reg : {finish(t_q), finish(t_i)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= entry_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/iq_phase_rotator.sv @@
// Top level of the I/Q phase rotator.
`default_nettype none

// The rotator takes one transaction per clock cycle while the queue is not full and
// delivers the results in their order of acceptance. Each sample passes a
// four-entry queue and then a three-stage datapath: a two-port quarter-wave cosine
// table read, the four products, and the sum with re-offset and saturation. A stall
// on the output freezes the datapath while the queue keeps accepting until full.
// In fixed mode every sample is rotated by phase_step; in drift mode the angle grows
// by phase_step per sample. The first sample after reset passes unrotated.
// Configuration writes take effect at once and belong to idle periods.

module iq_phase_rotator #(
    parameter int ANGLE_BITS = irot_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_BITS  = irot_pkg::TRIG_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [irot_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [irot_pkg::PHASE_W-1:0]    cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: i_raw, q_raw.
    input  wire logic [irot_pkg::DATA_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // Fields from bit 0 up: i_rot, q_rot.
    output logic [irot_pkg::DATA_W-1:0]          m_axis_tdata
);

    localparam int ENTRY_W = irot_pkg::DATA_W + ANGLE_BITS + 1;

    logic               push;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_entry;
    logic               pop;
    logic               pop_valid;
    logic [ENTRY_W-1:0] pop_entry;

    irot_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_axis_tvalid),
        .in_data     (s_axis_tdata),
        .queue_ready (push_ready),
        .push        (push),
        .entry       (push_entry)
    );

    irot_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (irot_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_entry)
    );

    irot_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .TRIG_BITS  (TRIG_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (pop_valid),
        .entry       (pop_entry),
        .entry_pop   (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

    assign s_axis_tready = push_ready;

endmodule

`default_nettype wire

@@ hw/rtl/irot_checker.sv @@
// Port-level assertions for the phase rotator and their binding to the top level.
`default_nettype none
`include "iq_phase_rotator_defines.svh"

module irot_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic [irot_pkg::DATA_W-1:0] s_axis_tdata,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [irot_pkg::DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(irot_pkg::MAX_IN_FLIGHT + 2);

    logic                        in_xfer;
    logic                        out_xfer;
    logic [CNT_W-1:0]            pending_reg;
    logic [CNT_W-1:0]            pending_next;
    logic                        seen_in_reg;
    logic                        seen_out_reg;
    logic [irot_pkg::DATA_W-1:0] first_data_reg;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            seen_in_reg  <= 1'b0;
            seen_out_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (in_xfer)
            begin
                seen_in_reg <= 1'b1;
            end
            if (out_xfer)
            begin
                seen_out_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && !seen_in_reg)
        begin
            first_data_reg <= s_axis_tdata;
        end
    end

    // Every result belongs to an accepted transaction.
    `IRP_ASSERT_IMPL(a_no_orphan_result, m_axis_tvalid, pending_reg != '0, "result without a pending transaction")

    // The queue and datapath bound the number of transactions in flight.
    `IRP_ASSERT(a_in_flight_bound, pending_reg <= CNT_W'(irot_pkg::MAX_IN_FLIGHT), "too many transactions in flight")

    // The first sample after reset leaves unrotated.
    `IRP_ASSERT_IMPL(a_first_passthrough, out_xfer && !seen_out_reg, m_axis_tdata == first_data_reg, "first sample was altered")

    // A stalled result stays valid.
    `IRP_ASSERT_IMPL(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "result dropped while stalled")

endmodule

bind iq_phase_rotator irot_checker u_irot_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
